>>> rtl/iab_pkg.sv
// Package for the bitmap identifier allocator: command and status codes,
// sequencer states and the word scan result type.
// No dependencies; every other file of the block imports it.
package iab_pkg;

  localparam int unsigned ID_W       = 32;
  localparam int unsigned WORD_BITS  = 32;
  localparam int unsigned BIT_W      = 5;
  localparam logic [ID_W-1:0] BASE_RESET = 32'd7011;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [1:0] {
    CMD_ALLOC    = 2'd0,
    CMD_CHECK    = 2'd1,
    CMD_REGISTER = 2'd2,
    CMD_RELEASE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OUTSIDE = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_MODIFY,
    S_SCAN,
    S_RESP
  } state_t;

  // Outcome of examining one bitmap word during an allocate scan.
  typedef struct packed {
    logic             found;
    logic             run_out;
    logic [BIT_W-1:0] bit_idx;
    word_t            free_oh;
    word_t            new_word;
  } scan_res_t;

endpackage

>>> rtl/iab_if.sv
// Handshake interfaces for the command and response channels.
// Depends on iab_pkg for the command and status types.
interface iab_cmd_if;
  import iab_pkg::*;
  logic            valid;
  logic            ready;
  cmd_t            command;
  logic [ID_W-1:0] cc_id;
  modport source(output valid, command, cc_id, input ready);
  modport sink(input valid, command, cc_id, output ready);
endinterface

interface iab_rsp_if;
  import iab_pkg::*;
  logic            valid;
  logic            ready;
  logic [ID_W-1:0] result_id;
  logic            answer;
  status_t         status;
  modport source(output valid, result_id, answer, status, input ready);
  modport sink(input valid, result_id, answer, status, output ready);
endinterface

>>> rtl/iab_map_ram.sv
// Bitmap storage: one write port and one read port with registered read data.
// Depends on iab_pkg for the word type.
module iab_map_ram #(
  parameter int unsigned DEPTH  = 8,
  parameter int unsigned ADDR_W = 3
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  iab_pkg::word_t    wdata,
  input  logic [ADDR_W-1:0] raddr,
  output iab_pkg::word_t    rdata
);
  import iab_pkg::*;

  word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/iab_word_scan.sv
// Examines one bitmap word of an allocate scan and finds the first free bit
// after the run of assigned bits. Depends on iab_pkg.
module iab_word_scan (
  input  iab_pkg::word_t    word,
  input  logic              run,
  output iab_pkg::scan_res_t res
);
  import iab_pkg::*;

  word_t                low;
  logic [WORD_BITS:0]   sum;
  word_t                free_oh;
  logic [BIT_W-1:0]     idx;

  // Adding the lowest set bit (or one, when a run carries in from the word
  // below) ripples through the run; the first cleared bit it lands on is free.
  always_comb begin
    low     = run ? word_t'(1) : (word & (~word + word_t'(1)));
    sum     = {1'b0, word} + {1'b0, low};
    free_oh = sum[WORD_BITS-1:0] & ~word;
    idx     = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      if (free_oh[b]) begin
        idx = idx | BIT_W'(b);
      end
    end
    res.found    = |free_oh;
    res.run_out  = run || (word != '0);
    res.bit_idx  = idx;
    res.free_oh  = free_oh;
    res.new_word = word | free_oh;
  end

endmodule

>>> rtl/identifier_allocator_bitmap.sv
// Top level of the bitmap identifier allocator: sequencer, configuration
// register and response register. Depends on iab_pkg, iab_if, iab_map_ram
// and iab_word_scan.
//
// The block keeps the assigned identifiers of a window of ID_COUNT values
// starting at base_id as a bitmap in one synchronous memory of ID_COUNT/32
// words, and serves one command at a time. After reset a clearing pass writes
// every word to zero, one per cycle, and no command is taken during it.
// Check, register and release pass through accept, memory read,
// read-modify-write and response load; an identifier outside the window goes
// from accept straight to response load. Allocate scans the bitmap one word
// per cycle through the memory read port and stops once the free bit is
// found; on an empty set it takes the register path for offset zero. A
// finished result sits in the response register, and the next command is
// accepted while it waits to be taken. Commands never overlap, so the write of
// one command always lands before the read of the next. base_id may be written
// only while the block is idle; the bitmap is relative to the window, so it
// follows a new base.
module identifier_allocator_bitmap #(
  parameter int unsigned ID_COUNT = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [iab_pkg::ID_W-1:0] cfg_wr_data,
  iab_cmd_if.sink              cmd,
  iab_rsp_if.source            rsp
);
  import iab_pkg::*;

  localparam int unsigned MAP_WORDS = (ID_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned OFF_W     = ADDR_W + BIT_W;
  localparam int unsigned CNT_W     = $clog2(ID_COUNT + 1);
  localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(MAP_WORDS - 1);

  // Control registers.
  state_t              state, state_next;
  logic [CNT_W-1:0]    cnt, cnt_next;
  logic [ADDR_W-1:0]   clr_k, clr_k_next;
  logic                ev_vld, ev_vld_next;
  logic                out_valid, out_valid_next;
  logic [ID_W-1:0]     base_id;

  // Per-command working registers.
  cmd_t                op, op_next;
  logic [OFF_W-1:0]    off, off_next;
  logic [OFF_W-1:0]    pos, pos_next;
  logic                from_pos, from_pos_next;
  logic [ADDR_W-1:0]   scan_k, scan_k_next;
  logic [ADDR_W-1:0]   ev_k, ev_k_next;
  logic                run, run_next;
  logic [ID_W-1:0]     res_id, res_id_next;
  logic                res_ans, res_ans_next;
  status_t             res_st, res_st_next;

  // Response register.
  logic [ID_W-1:0]     out_id, out_id_next;
  logic                out_ans, out_ans_next;
  status_t             out_st, out_st_next;

  // Memory ports.
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  word_t               ram_wdata;
  logic [ADDR_W-1:0]   ram_raddr;
  word_t               ram_rdata;

  scan_res_t           scan;
  logic [ID_W-1:0]     cmd_off;
  logic                in_window;
  logic [OFF_W-1:0]    pos_c;
  word_t               bit_mask;
  logic                bit_val;

  iab_map_ram #(
    .DEPTH (MAP_WORDS),
    .ADDR_W(ADDR_W)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  iab_word_scan u_scan (
    .word(ram_rdata),
    .run (run),
    .res (scan)
  );

  // The window wraps modulo 2^32, so a plain unsigned difference decides it.
  assign cmd_off   = cmd.cc_id - base_id;
  assign in_window = cmd_off < ID_W'(ID_COUNT);
  assign pos_c     = {ev_k, scan.bit_idx};
  assign bit_mask  = word_t'(1) << off[BIT_W-1:0];
  assign bit_val   = ram_rdata[off[BIT_W-1:0]];

  assign cmd.ready     = (state == S_IDLE);
  assign rsp.valid     = out_valid;
  assign rsp.result_id = out_id;
  assign rsp.answer    = out_ans;
  assign rsp.status    = out_st;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_id <= BASE_RESET;
    end else if (cfg_wr_en) begin
      base_id <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      cnt       <= '0;
      clr_k     <= '0;
      ev_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      clr_k     <= clr_k_next;
      ev_vld    <= ev_vld_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    op       <= op_next;
    off      <= off_next;
    pos      <= pos_next;
    from_pos <= from_pos_next;
    scan_k   <= scan_k_next;
    ev_k     <= ev_k_next;
    run      <= run_next;
    res_id   <= res_id_next;
    res_ans  <= res_ans_next;
    res_st   <= res_st_next;
    out_id   <= out_id_next;
    out_ans  <= out_ans_next;
    out_st   <= out_st_next;
  end

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    clr_k_next     = clr_k;
    ev_vld_next    = ev_vld;
    out_valid_next = out_valid & ~rsp.ready;
    op_next        = op;
    off_next       = off;
    pos_next       = pos;
    from_pos_next  = from_pos;
    scan_k_next    = scan_k;
    ev_k_next      = ev_k;
    run_next       = run;
    res_id_next    = res_id;
    res_ans_next   = res_ans;
    res_st_next    = res_st;
    out_id_next    = out_id;
    out_ans_next   = out_ans;
    out_st_next    = out_st;
    ram_we         = 1'b0;
    ram_waddr      = off[OFF_W-1:BIT_W];
    ram_wdata      = '0;
    ram_raddr      = scan_k;

    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_k;
        ram_wdata = '0;
        if (clr_k == LAST_WORD) begin
          state_next = S_IDLE;
        end else begin
          clr_k_next = clr_k + ADDR_W'(1);
        end
      end

      S_IDLE: begin
        if (cmd.valid) begin
          op_next       = cmd.command;
          res_id_next   = cmd.cc_id;
          res_ans_next  = 1'b0;
          res_st_next   = ST_OK;
          from_pos_next = 1'b0;
          if (cmd.command == CMD_ALLOC) begin
            if (cnt == '0) begin
              // Empty set: hand out the base, which is a register of offset zero.
              op_next       = CMD_REGISTER;
              off_next      = '0;
              pos_next      = '0;
              from_pos_next = 1'b1;
              state_next    = S_LOOK;
            end else begin
              scan_k_next = '0;
              ev_vld_next = 1'b0;
              run_next    = 1'b0;
              state_next  = S_SCAN;
            end
          end else if (!in_window) begin
            res_st_next  = ST_OUTSIDE;
            res_ans_next = (cmd.command == CMD_CHECK);
            state_next   = S_RESP;
          end else begin
            off_next   = cmd_off[OFF_W-1:0];
            state_next = S_LOOK;
          end
        end
      end

      S_LOOK: begin
        ram_raddr  = off[OFF_W-1:BIT_W];
        state_next = S_MODIFY;
      end

      S_MODIFY: begin
        case (op)
          CMD_CHECK: begin
            res_ans_next = ~bit_val;
          end
          CMD_REGISTER: begin
            if (!bit_val) begin
              ram_we       = 1'b1;
              ram_wdata    = ram_rdata | bit_mask;
              cnt_next     = cnt + CNT_W'(1);
              res_ans_next = 1'b1;
            end
          end
          CMD_RELEASE: begin
            if (bit_val) begin
              ram_we       = 1'b1;
              ram_wdata    = ram_rdata & ~bit_mask;
              cnt_next     = cnt - CNT_W'(1);
              res_ans_next = 1'b1;
            end
          end
          default: begin
          end
        endcase
        state_next = S_RESP;
      end

      S_SCAN: begin
        // One word is read per cycle while the word read before it is examined.
        ram_raddr   = scan_k;
        ev_vld_next = 1'b1;
        ev_k_next   = scan_k;
        if (scan_k != LAST_WORD) begin
          scan_k_next = scan_k + ADDR_W'(1);
        end
        if (ev_vld) begin
          if (scan.found && (ID_W'(pos_c) < ID_W'(ID_COUNT))) begin
            ram_we        = 1'b1;
            ram_waddr     = ev_k;
            ram_wdata     = scan.new_word;
            cnt_next      = cnt + CNT_W'(1);
            pos_next      = pos_c;
            from_pos_next = 1'b1;
            res_ans_next  = 1'b1;
            state_next    = S_RESP;
          end else if (scan.found || (ev_k == LAST_WORD)) begin
            // The run of assigned identifiers reaches the end of the window.
            res_id_next  = '0;
            res_ans_next = 1'b0;
            res_st_next  = ST_FULL;
            state_next   = S_RESP;
          end else begin
            run_next = scan.run_out;
          end
        end
      end

      S_RESP: begin
        if (!out_valid || rsp.ready) begin
          out_valid_next = 1'b1;
          out_id_next    = from_pos ? (base_id + ID_W'(pos)) : res_id;
          out_ans_next   = res_ans;
          out_st_next    = res_st;
          state_next     = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(ID_COUNT))
    else $error("assigned count exceeds the window size");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready) |=> (state != S_IDLE))
    else $error("accepted command did not start work");

  a_scan_single_bit: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && ev_vld) |-> $onehot0(scan.free_oh))
    else $error("word scan marked more than one free bit");

  a_scan_write_sets_new: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && ram_we) |-> (ram_wdata != ram_rdata))
    else $error("allocate wrote back an unchanged word");

  a_release_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_MODIFY && op == CMD_RELEASE && ram_we) |-> (cnt != '0))
    else $error("release of a present identifier with an empty count");
`endif

endmodule
